FILE: src/bfm_pkg.sv
`default_nettype none

package bfm_pkg;

    // Frame and line store geometry.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int LINES      = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_W     = $clog2(LINES);
    localparam int ADDR_W     = LINE_W + COL_W;
    localparam int DEPTH      = LINES * MAX_WIDTH;
    localparam int DIM_W      = COL_W + 1;
    localparam int POS_W      = COL_W + ROW_W + 1;
    localparam int LAG_W      = DIM_W + 3;
    localparam int SUM_W      = 16;
    localparam int AREA_W     = 8;
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int IDX_W      = 3;
    localparam int COORD_W    = DIM_W + 2;

    // Item commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_IMG_WIDTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMG_HEIGHT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Mirror a coordinate into 0..n-1 without repeating the edge.
    function automatic logic [COL_W-1:0] mirror101(
        input logic signed [COORD_W-1:0] i,
        input logic        [DIM_W-1:0]   n
    );
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] ns;
        a  = (i < 0) ? -i : i;
        ns = $signed({2'b00, n});
        if (a >= ns)
        begin
            a = (ns <<< 1) - COORD_W'(2) - a;
        end
        if (a < 0)
        begin
            a = '0;
        end
        if (a > ns - COORD_W'(1))
        begin
            a = ns - COORD_W'(1);
        end
        return a[COL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/bfm_in_if.sv
`default_nettype none

interface bfm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

`default_nettype wire

FILE: src/bfm_out_if.sv
`default_nettype none

interface bfm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mean;
    logic       frame_last;

    modport source (output valid, output mean, output frame_last, input ready);
    modport sink   (input valid, input mean, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: src/bfm_ram.sv
`default_nettype none

module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

FILE: src/bfm_div.sv
`default_nettype none

module bfm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bfm_pkg::SUM_W-1:0]     num,
    input  wire logic [bfm_pkg::AREA_W-1:0]    den,
    output logic                               done,
    output logic [bfm_pkg::PIX_W-1:0]          quo
);
    import bfm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [AREA_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [AREA_W-1:0] den_reg, den_next;
    logic [AREA_W:0]   trial;
    logic [AREA_W:0]   diff;

    // One quotient bit per cycle, restoring division.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        trial     = {rem_reg, q_reg[SUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor.
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[AREA_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[AREA_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg[PIX_W-1:0];
endmodule

`default_nettype wire

FILE: src/box_filter_mean.sv
`default_nettype none

// Box filter mean with mirrored (reflect101) borders over an 8-bit grey frame in
// raster order. An item that yields an output is accepted, then the line store is
// read once per window pixel through its single read port, with the window area
// (2*(kernel_width/2)+1)*(2*(kernel_height/2)+1), the last read is collected, the
// bit-serial divider forms 16 quotient bits for the rounded mean, and the result
// waits until it is transferred; no new item is accepted meanwhile. Outputs trail
// the input by (kernel_height/2) rows plus (kernel_width/2) pixels; flush items
// release the outputs still owed once a frame is complete. A configuration write
// to any of the four registers restarts the frame.
module box_filter_mean (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bfm_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [bfm_pkg::CFG_W-1:0]    cfg_data,
    bfm_in_if.sink                            pixels,
    bfm_out_if.source                         results
);
    import bfm_pkg::*;

    state_t state_reg, state_next;

    logic [11:0] img_w_reg, img_w_next;
    logic [11:0] img_h_reg, img_h_next;
    logic [3:0]  kw_reg, kw_next;
    logic [3:0]  kh_reg, kh_next;

    logic [POS_W-1:0] in_cnt_reg, in_cnt_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [POS_W-1:0] out_cnt_reg, out_cnt_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic signed [4:0] dx_reg, dx_next;
    logic signed [4:0] dy_reg, dy_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PIX_W-1:0]  mean_reg, mean_next;
    logic              last_reg, last_next;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [2:0]        rx, ry;
    logic [LAG_W-1:0]  lag;
    logic [POS_W-1:0]  total;
    logic [AREA_W-1:0] area;
    logic              accept, is_pix, pix_ok, emit;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [PIX_W-1:0]  rdata;
    logic signed [COORD_W-1:0] xi, yi;
    logic [COL_W-1:0]  cx, cy;
    logic [SUM_W-1:0]  div_num;
    logic              div_done;
    logic [PIX_W-1:0]  div_quo;

    // Effective geometry from the registers.
    always_comb
    begin
        if (img_w_reg == '0)
            w_eff = DIM_W'(1);
        else if ({1'b0, img_w_reg} > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(img_w_reg);
        if (img_h_reg == '0)
            h_eff = DIM_W'(1);
        else if ({1'b0, img_h_reg} > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(img_h_reg);
    end

    assign rx    = kw_reg[3:1];
    assign ry    = kh_reg[3:1];
    assign lag   = LAG_W'(ry) * LAG_W'(w_eff) + LAG_W'(rx);
    assign total = POS_W'(w_eff) * POS_W'(h_eff);
    assign area  = AREA_W'({rx, 1'b1}) * AREA_W'({ry, 1'b1});

    // Input decisions.
    assign pixels.ready = (state_reg == ST_IDLE);
    assign accept  = pixels.valid && pixels.ready;
    assign is_pix  = (pixels.cmd == CMD_PIXEL);
    assign pix_ok  = is_pix && (in_cnt_reg < total);
    assign emit    = pix_ok
        ? ((out_cnt_reg + POS_W'(lag)) < (in_cnt_reg + POS_W'(1)))
        : (!is_pix && (in_cnt_reg >= total) && (out_cnt_reg < total));
    assign mem_we  = accept && pix_ok;
    assign waddr   = {in_row_reg[LINE_W-1:0], in_col_reg};

    // Window read address with mirrored borders.
    assign xi    = $signed({2'b00, out_col_reg}) + COORD_W'(dx_reg);
    assign yi    = $signed({2'b00, out_row_reg}) + COORD_W'(dy_reg);
    assign cx    = mirror101(xi, w_eff);
    assign cy    = mirror101(yi, h_eff);
    assign raddr = {cy[LINE_W-1:0], cx};

    assign div_num = sum_reg + SUM_W'(rdata) + SUM_W'(area >> 1);

    bfm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (pixels.pixel),
        .raddr (raddr),
        .rdata (rdata)
    );

    bfm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DRAIN),
        .num   (div_num),
        .den   (area),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer and position tracking.
    always_comb
    begin
        state_next    = state_reg;
        img_w_next    = img_w_reg;
        img_h_next    = img_h_reg;
        kw_next       = kw_reg;
        kh_next       = kh_reg;
        in_cnt_next   = in_cnt_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_cnt_next  = out_cnt_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        rd_valid_next = 1'b0;
        sum_next      = sum_reg;
        mean_next     = mean_reg;
        last_next     = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pix_ok)
                    begin
                        in_cnt_next = in_cnt_reg + POS_W'(1);
                        if ({1'b0, in_col_reg} == w_eff - DIM_W'(1))
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                    end
                    if (emit)
                    begin
                        dx_next    = -$signed({2'b00, rx});
                        dy_next    = -$signed({2'b00, ry});
                        sum_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                rd_valid_next = 1'b1;
                if (rd_valid_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rdata);
                end
                if (dy_reg == $signed({2'b00, ry}))
                begin
                    dy_next = -$signed({2'b00, ry});
                    dx_next = dx_reg + 5'sd1;
                    if (dx_reg == $signed({2'b00, rx}))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    dy_next = dy_reg + 5'sd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo;
                    last_next  = (out_cnt_reg + POS_W'(1) == total);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (results.ready)
                begin
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        in_cnt_next  = '0;
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_cnt_next = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_cnt_next = out_cnt_reg + POS_W'(1);
                        if ({1'b0, out_col_reg} == w_eff - DIM_W'(1))
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + COL_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A configuration write to one of the four registers restarts the frame.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMG_WIDTH:     img_w_next = cfg_data;
                REG_IMG_HEIGHT:    img_h_next = cfg_data;
                REG_KERNEL_WIDTH:  kw_next    = cfg_data[3:0];
                REG_KERNEL_HEIGHT: kh_next    = cfg_data[3:0];
                default:           ;
            endcase
            if (cfg_index <= REG_KERNEL_HEIGHT)
            begin
                in_cnt_next  = '0;
                in_col_next  = '0;
                in_row_next  = '0;
                out_cnt_next = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            img_w_reg    <= 12'd640;
            img_h_reg    <= 12'd480;
            kw_reg       <= 4'd3;
            kh_reg       <= 4'd3;
            in_cnt_reg   <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_cnt_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            img_w_reg    <= img_w_next;
            img_h_reg    <= img_h_next;
            kw_reg       <= kw_next;
            kh_reg       <= kh_next;
            in_cnt_reg   <= in_cnt_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_cnt_reg  <= out_cnt_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sum_reg  <= sum_next;
        mean_reg <= mean_next;
        last_reg <= last_next;
    end

    // Result transfer.
    assign results.valid      = (state_reg == ST_OUT);
    assign results.mean       = mean_reg;
    assign results.frame_last = last_reg;
endmodule

`default_nettype wire

FILE: tb/tb_box_filter_mean.sv
`timescale 1ns / 1ps

module tb_box_filter_mean;

    import bfm_pkg::*;

    localparam int LIMIT_CYCLES = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1600;

    // Indexes that decode to no register.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd4;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] mean;
        logic       frame_last;
    } window_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bfm_in_if  pix_if ();
    bfm_out_if res_if ();

    box_filter_mean i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_if.sink),
        .results   (res_if.source)
    );

    // Shadow copy of the filter state.
    logic [7:0]      line_copy [LINES*MAX_WIDTH];
    logic [11:0]     shadow_w;
    logic [11:0]     shadow_h;
    logic [3:0]      shadow_kw;
    logic [3:0]      shadow_kh;
    int unsigned     pix_count;
    int unsigned     mean_count;

    window_out_t     pending_means [$];
    int              errors = 0;
    int              items_sent;
    int              idle_cycles = 0;
    bit              quiet;

    always #6 clk = ~clk;

    // Result side back-pressure.
    always @(posedge clk)
    begin
        res_if.ready <= quiet || ($urandom_range(0, 99) >= 11);
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        window_out_t want;
        if (res_if.valid && res_if.ready)
        begin
            if (pending_means.size() == 0)
            begin
                $error("unexpected result mean=%0d frame_last=%0d",
                       res_if.mean, res_if.frame_last);
                errors++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (want.mean !== res_if.mean)
                begin
                    $error("mean: expected %0d, got %0d", want.mean, res_if.mean);
                    errors++;
                end
                if (want.frame_last !== res_if.frame_last)
                begin
                    $error("frame_last: expected %0d, got %0d",
                           want.frame_last, res_if.frame_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT_CYCLES)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int clamp_dim(int v);
        if (v < 1)
        begin
            return 1;
        end
        if (v > MAX_WIDTH)
        begin
            return MAX_WIDTH;
        end
        return v;
    endfunction

    function automatic int radius_of(logic [3:0] k);
        int r;
        r = int'(k | 4'd1) / 2;
        return (r > 7) ? 7 : r;
    endfunction

    // Mirror without repeating the edge, then clamp into the frame.
    function automatic int fold(int i, int n);
        int a;
        a = (i < 0) ? -i : i;
        if (a >= n)
        begin
            a = 2 * n - 2 - a;
        end
        if (a < 0)
        begin
            a = 0;
        end
        if (a > n - 1)
        begin
            a = n - 1;
        end
        return a;
    endfunction

    function automatic int lag_now();
        return radius_of(shadow_kh) * clamp_dim(shadow_w) + radius_of(shadow_kw);
    endfunction

    // Update the shadow state for one accepted item and queue any result.
    task automatic predict_mean(logic cmd, logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned owed;
        int unsigned area;
        int unsigned sum;
        int rx;
        int ry;
        int oy;
        int ox;
        window_out_t res;
        w = clamp_dim(shadow_w);
        h = clamp_dim(shadow_h);
        total = w * h;
        rx = radius_of(shadow_kw);
        ry = radius_of(shadow_kh);
        if (pix_count > total)
        begin
            pix_count = total;
        end
        if (mean_count > pix_count)
        begin
            mean_count = pix_count;
        end
        if (cmd == CMD_PIXEL)
        begin
            if (pix_count >= total)
            begin
                return;
            end
            line_copy[((pix_count / w) % LINES) * MAX_WIDTH + (pix_count % w)] = pix;
            pix_count++;
            owed = (pix_count > ry * w + rx) ? pix_count - (ry * w + rx) : 0;
        end
        else
        begin
            if (pix_count < total)
            begin
                return;
            end
            owed = total;
        end
        if (mean_count >= owed)
        begin
            return;
        end
        oy = mean_count / w;
        ox = mean_count % w;
        area = (2 * rx + 1) * (2 * ry + 1);
        sum = 0;
        for (int dx = -rx; dx <= rx; dx++)
        begin
            for (int dy = -ry; dy <= ry; dy++)
            begin
                sum += line_copy[(fold(oy + dy, h) % LINES) * MAX_WIDTH
                                 + fold(ox + dx, w)];
            end
        end
        res.mean = 8'((sum + area / 2) / area);
        res.frame_last = (mean_count + 1 == total);
        pending_means.push_back(res);
        mean_count++;
        if (res.frame_last)
        begin
            pix_count = 0;
            mean_count = 0;
        end
    endtask

    // Offer one item, with random gaps, and hold it until the transfer.
    task automatic send_item(logic cmd, logic [7:0] pix);
        while (!quiet && $urandom_range(0, 99) < 11)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.cmd   <= cmd;
        pix_if.pixel <= pix;
        @(posedge clk);
        while (!pix_if.ready)
        begin
            @(posedge clk);
        end
        predict_mean(cmd, pix);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has come.
    task automatic drain();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_IMG_WIDTH:     shadow_w  = val;
            REG_IMG_HEIGHT:    shadow_h  = val;
            REG_KERNEL_WIDTH:  shadow_kw = val[3:0];
            REG_KERNEL_HEIGHT: shadow_kh = val[3:0];
            default:           return;
        endcase
        pix_count = 0;
        mean_count = 0;
    endtask

    task automatic set_geometry(int w, int h, int kw, int kh);
        drain();
        write_reg(REG_IMG_WIDTH, CFG_W'(w));
        write_reg(REG_IMG_HEIGHT, CFG_W'(h));
        write_reg(REG_KERNEL_WIDTH, CFG_W'(kw));
        write_reg(REG_KERNEL_HEIGHT, CFG_W'(kh));
        cfg_we <= 1'b0;
    endtask

    // Flushes that release the owed outputs, plus a few that find nothing.
    task automatic flush_frame(int extra);
        int n;
        n = lag_now() + extra;
        for (int i = 0; i < n; i++)
        begin
            send_item(CMD_FLUSH, 8'($urandom));
        end
    endtask

    // Small frame: early flush, extreme pixels, pixel after a full frame.
    task automatic test_directed();
        set_geometry(4, 3, 3, 3);
        send_item(CMD_FLUSH, 8'hff);
        for (int i = 0; i < 12; i++)
        begin
            send_item(CMD_PIXEL, (i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'hff : 8'h5a));
        end
        send_item(CMD_PIXEL, 8'hff);
        flush_frame(1);
    endtask

    // Writes to unused indexes must not restart the frame.
    task automatic test_unknown_index();
        set_geometry(5, 4, 3, 2);
        for (int i = 0; i < 8; i++)
        begin
            send_item(CMD_PIXEL, 8'($urandom));
        end
        drain();
        write_reg(REG_SPARE_LO, 12'hfff);
        write_reg(REG_SPARE_HI, 12'h001);
        cfg_we <= 1'b0;
        for (int i = 8; i < 20; i++)
        begin
            send_item(CMD_PIXEL, 8'($urandom));
        end
        flush_frame(0);
    endtask

    // Width above the maximum, zero height and zero kernels, at full rate.
    task automatic test_clamped_geometry();
        set_geometry(12'hfff, 0, 0, 0);
        quiet = 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            send_item(CMD_PIXEL, 8'($urandom));
        end
        quiet = 1'b0;
    endtask

    // Largest kernels on frames narrower than the radius.
    task automatic test_wide_kernels();
        set_geometry(3, 2, 15, 15);
        for (int f = 0; f < 2; f++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                send_item(CMD_PIXEL, 8'($urandom));
            end
            flush_frame(1);
        end
        set_geometry(1, 9, 14, 15);
        for (int i = 0; i < 9; i++)
        begin
            send_item(CMD_PIXEL, 8'hff);
        end
        flush_frame(0);
    endtask

    // Random frames with noise, broken frames and one full pause.
    task automatic test_random_frames();
        int frames;
        int w;
        int h;
        int total;
        int cut;
        int start;
        frames = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            w = $urandom_range(0, 24);
            h = $urandom_range(0, 20);
            set_geometry(w, h,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 5),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 5));
            total = clamp_dim(w) * clamp_dim(h);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
            for (int i = 0; i < cut; i++)
            begin
                if ($urandom_range(0, 99) < 3)
                begin
                    send_item(CMD_FLUSH, 8'($urandom));
                end
                send_item(CMD_PIXEL, ($urandom_range(0, 19) == 0) ? 8'hff : 8'($urandom));
                if (frames == 3 && i == cut / 2)
                begin
                    drain();
                end
            end
            if (cut == total)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_item(CMD_PIXEL, 8'($urandom));
                end
                flush_frame($urandom_range(0, 2));
            end
            frames++;
        end
    endtask

    initial
    begin
        items_sent = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMG_WIDTH;
        cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.cmd = CMD_PIXEL;
        pix_if.pixel = 8'h00;
        shadow_w = 12'd640;
        shadow_h = 12'd480;
        shadow_kw = 4'd3;
        shadow_kh = 4'd3;
        pix_count = 0;
        mean_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_unknown_index();
        test_clamped_geometry();
        test_wide_kernels();
        test_random_frames();
        drain();

        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
